@@ rtl/assert_macros.svh @@
// assertion macros shared by the gesture recognizer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TPDP_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tpdp_pkg.sv @@
// types, constants and width helpers of the gesture recognizer
package tpdp_pkg;

    localparam int DEF_COORD_BITS = 16;
    localparam int DEF_ID_BITS    = 8;
    localparam int TOL_BITS       = 16;
    localparam int TOL_RESET      = 16;
    localparam int ZOOM_BITS      = 32;
    localparam int FRAC_BITS      = 32;
    localparam int Q_BITS         = 64;
    localparam int SQRT_STEPS     = 32;
    localparam int TABLE_SIZE     = 3;

    typedef enum logic [1:0] {
        OP_DOWN, OP_UP, OP_MOVE, OP_OTHER
    } t_op;

    typedef enum logic [2:0] {
        MODE_IDLE, MODE_PRESS, MODE_DRAG, MODE_XFORM, MODE_NONE
    } t_mode;

    typedef enum logic [2:0] {
        G_PRESS_START, G_PRESS_ABORT, G_PRESS_END, G_DRAG_START,
        G_DRAG_MOVE, G_DRAG_END, G_ZOOM
    } t_gesture;

    typedef enum logic [2:0] {
        SQ_DXP, SQ_DYP, SQ_TOL, SQ_DXO, SQ_DYO, SQ_DXN, SQ_DYN
    } t_sq_sel;

    typedef enum logic [2:0] {
        ACC_HOLD, ACC_LOAD0, ACC_ADD0, ACC_LOAD1, ACC_ADD1
    } t_acc_op;

    typedef enum logic [1:0] {
        ID_ZERO, ID_IN, ID_FIRST
    } t_id_src;

    typedef enum logic [1:0] {
        XY_ZERO, XY_IN, XY_FIRST, XY_ENTRY
    } t_xy_src;

    typedef enum logic [2:0] {
        TBL_HOLD, TBL_INSERT, TBL_REMOVE, TBL_CLEAR, TBL_WRITE
    } t_tbl_op;

    typedef enum logic [3:0] {
        ACT_DOWN_IDLE, ACT_DOWN_PRESS, ACT_DOWN_DRAG, ACT_DOWN_XFORM,
        ACT_UP_NONE, ACT_UP_XFORM, ACT_UP_DRAG, ACT_UP_PRESS,
        ACT_MOVE_DRAG, ACT_MOVE_PRESS, ACT_MOVE_XFORM
    } t_act;

    typedef enum logic [3:0] {
        ST_READY, ST_LOOK, ST_DISPATCH, ST_SQ0, ST_SQ1, ST_SQ2, ST_SQ3, ST_SQ4,
        ST_DECIDE, ST_DIV, ST_SQRT_INIT, ST_SQRT, ST_EMIT, ST_UPDATE
    } t_state;

    typedef struct packed {
        logic     in_load;
        logic     look_en;
        t_sq_sel  sq_sel;
        t_acc_op  acc_op;
        logic     div_init;
        logic     div_step;
        logic     sqrt_init;
        logic     sqrt_step;
        logic     emit_en;
        t_gesture emit_kind;
        t_id_src  id_src;
        t_xy_src  xy_src;
        logic     emit_last;
        t_tbl_op  tbl_op;
        logic     mode_we;
        t_mode    mode_val;
    } t_dp_cmd;

    typedef struct packed {
        t_op   op;
        t_mode mode;
        logic  found;
        logic  pair_ok;
        logic  empty_wo_s;
        logic  d2_gt;
        logic  spans_nz;
        logic  out_free;
    } t_dp_status;

    function automatic int f_mul_w(input int coord_bits);
        return (coord_bits + 1 > TOL_BITS) ? coord_bits + 1 : TOL_BITS;
    endfunction

    function automatic int f_acc_w(input int coord_bits);
        return 2 * f_mul_w(coord_bits) + 1;
    endfunction

    function automatic int f_div_steps(input int coord_bits);
        return f_acc_w(coord_bits) + FRAC_BITS;
    endfunction

endpackage

@@ rtl/tpdp_datapath.sv @@
// pointer table, squarer, divider, square root and output register
`include "assert_macros.svh"

module tpdp_datapath
    import tpdp_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int ID_BITS    = DEF_ID_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    output t_dp_status                   o_status,
    input  logic                         i_cfg_we,
    input  logic [TOL_BITS-1:0]          i_cfg_data,
    input  logic [1:0]                   i_operation,
    input  logic [ID_BITS-1:0]           i_pointer_id,
    input  logic [1:0]                   i_pointer_kind,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [2:0]                   o_gesture_kind,
    output logic [1:0]                   o_out_pointer_kind,
    output logic [ID_BITS-1:0]           o_out_pointer_id,
    output logic signed [COORD_BITS-1:0] o_out_x,
    output logic signed [COORD_BITS-1:0] o_out_y,
    output logic [ZOOM_BITS-1:0]         o_zoom_ratio,
    output logic                         o_last_of_run
);

    localparam int MUL_W     = f_mul_w(COORD_BITS);
    localparam int ACC_W     = f_acc_w(COORD_BITS);
    localparam int DIV_STEPS = f_div_steps(COORD_BITS);
    localparam int DIF_W     = COORD_BITS + 1;

    logic [TOL_BITS-1:0]          r_tol;
    t_mode                        r_mode;
    logic [TABLE_SIZE-1:0]        r_valid;
    logic [ID_BITS-1:0]           r_id [TABLE_SIZE];
    logic signed [COORD_BITS-1:0] r_x [TABLE_SIZE];
    logic signed [COORD_BITS-1:0] r_y [TABLE_SIZE];

    t_op                          r_op;
    logic [ID_BITS-1:0]           r_pid;
    logic [1:0]                   r_pkind;
    logic signed [COORD_BITS-1:0] r_px;
    logic signed [COORD_BITS-1:0] r_py;

    logic                         r_found;
    logic [TABLE_SIZE-1:0]        r_s_oh;
    logic                         r_s_is_a;
    logic                         r_s_is_b;
    logic                         r_pair_ok;
    logic                         r_empty_wo_s;
    logic [TABLE_SIZE-1:0]        r_free_oh;
    logic                         r_can_ins;
    logic [ID_BITS-1:0]           r_aid;
    logic signed [COORD_BITS-1:0] r_ax, r_ay, r_bx, r_by, r_ex, r_ey;

    logic [TABLE_SIZE-1:0]        hit_oh, free_oh, is_a, is_b;
    logic                         hit_found, free_found;
    logic [1:0]                   rank [TABLE_SIZE];
    logic [ID_BITS-1:0]           l_aid;
    logic signed [COORD_BITS-1:0] l_ax, l_ay, l_bx, l_by, l_ex, l_ey;

    logic signed [COORD_BITS-1:0] axn, ayn, bxn, byn;
    logic signed [DIF_W-1:0]      dif;
    logic [DIF_W-1:0]             mag;
    logic [MUL_W-1:0]             mul_op;
    logic [2*MUL_W-1:0]           r_prod;
    logic [ACC_W-1:0]             r_acc0, r_acc1;

    logic [DIV_STEPS-1:0]         r_num;
    logic [ACC_W-1:0]             r_rem;
    logic [Q_BITS-1:0]            r_q;
    logic                         r_ovf;
    logic [ACC_W:0]               rem_sh;
    logic                         div_ge;

    logic [Q_BITS-1:0]            r_v, r_res, r_bit;
    logic [Q_BITS-1:0]            sq_t;
    logic                         sq_ge;

    logic                         r_out_valid;
    t_gesture                     r_out_kind;
    logic [1:0]                   r_out_pkind;
    logic [ID_BITS-1:0]           r_out_id;
    logic signed [COORD_BITS-1:0] r_out_x, r_out_y;
    logic [ZOOM_BITS-1:0]         r_out_zoom;
    logic                         r_out_last;
    logic                         out_free;
    logic [ID_BITS-1:0]           n_out_id;
    logic signed [COORD_BITS-1:0] n_out_x, n_out_y;

    // table lookup: matching slot, lowest free slot, id ranks
    always_comb begin
        hit_oh     = '0;
        free_oh    = '0;
        hit_found  = 1'b0;
        free_found = 1'b0;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (r_valid[i] && r_id[i] == r_pid && !hit_found) begin
                hit_oh[i] = 1'b1;
                hit_found = 1'b1;
            end
            if (!r_valid[i] && !free_found) begin
                free_oh[i] = 1'b1;
                free_found = 1'b1;
            end
        end
        for (int i = 0; i < TABLE_SIZE; i++) begin
            rank[i] = 2'd0;
            for (int j = 0; j < TABLE_SIZE; j++) begin
                if (j != i && r_valid[j] &&
                    (r_id[j] < r_id[i] || (r_id[j] == r_id[i] && j < i))) begin
                    rank[i] = rank[i] + 2'd1;
                end
            end
            is_a[i] = r_valid[i] && rank[i] == 2'd0;
            is_b[i] = r_valid[i] && rank[i] == 2'd1;
        end
        l_aid = '0;
        l_ax  = '0;
        l_ay  = '0;
        l_bx  = '0;
        l_by  = '0;
        l_ex  = '0;
        l_ey  = '0;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (is_a[i]) begin
                l_aid = l_aid | r_id[i];
                l_ax  = l_ax | r_x[i];
                l_ay  = l_ay | r_y[i];
            end
            if (is_b[i]) begin
                l_bx = l_bx | r_x[i];
                l_by = l_by | r_y[i];
            end
            if (hit_oh[i]) begin
                l_ex = l_ex | r_x[i];
                l_ey = l_ey | r_y[i];
            end
        end
    end

    // squarer operand select
    always_comb begin
        axn = r_s_is_a ? r_px : r_ax;
        ayn = r_s_is_a ? r_py : r_ay;
        bxn = r_s_is_b ? r_px : r_bx;
        byn = r_s_is_b ? r_py : r_by;
        unique case (i_cmd.sq_sel)
            SQ_DXP:  dif = DIF_W'(r_px) - DIF_W'(r_ex);
            SQ_DYP:  dif = DIF_W'(r_py) - DIF_W'(r_ey);
            SQ_DXO:  dif = DIF_W'(r_bx) - DIF_W'(r_ax);
            SQ_DYO:  dif = DIF_W'(r_by) - DIF_W'(r_ay);
            SQ_DXN:  dif = DIF_W'(bxn) - DIF_W'(axn);
            SQ_DYN:  dif = DIF_W'(byn) - DIF_W'(ayn);
            default: dif = '0;
        endcase
        mag    = dif[DIF_W-1] ? DIF_W'(-dif) : DIF_W'(dif);
        mul_op = (i_cmd.sq_sel == SQ_TOL) ? MUL_W'(r_tol) : MUL_W'(mag);
    end

    // long division and square root steps
    always_comb begin
        rem_sh = {r_rem, r_num[DIV_STEPS-1]};
        div_ge = rem_sh >= {1'b0, r_acc1};
        sq_t   = r_res + r_bit;
        sq_ge  = r_v >= sq_t;
    end

    // output field select
    always_comb begin
        unique case (i_cmd.id_src)
            ID_IN:    n_out_id = r_pid;
            ID_FIRST: n_out_id = r_aid;
            default:  n_out_id = '0;
        endcase
        unique case (i_cmd.xy_src)
            XY_IN: begin
                n_out_x = r_px;
                n_out_y = r_py;
            end
            XY_FIRST: begin
                n_out_x = r_ax;
                n_out_y = r_ay;
            end
            XY_ENTRY: begin
                n_out_x = r_ex;
                n_out_y = r_ey;
            end
            default: begin
                n_out_x = '0;
                n_out_y = '0;
            end
        endcase
    end

    assign out_free = !r_out_valid || !i_stall;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol       <= TOL_BITS'(TOL_RESET);
            r_mode      <= MODE_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_data;
            end
            if (i_cmd.mode_we) begin
                r_mode <= i_cmd.mode_val;
            end
            unique case (i_cmd.tbl_op)
                TBL_INSERT: begin
                    if (r_can_ins) begin
                        r_valid <= r_valid | r_free_oh;
                    end
                end
                TBL_REMOVE: r_valid <= r_valid & ~r_s_oh;
                TBL_CLEAR:  r_valid <= '0;
                default:    r_valid <= r_valid;
            endcase
            if (i_cmd.emit_en) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_op    <= t_op'(i_operation);
            r_pid   <= i_pointer_id;
            r_pkind <= i_pointer_kind;
            r_px    <= i_pos_x;
            r_py    <= i_pos_y;
        end
        if (i_cmd.look_en) begin
            r_found      <= hit_found;
            r_s_oh       <= hit_oh;
            r_s_is_a     <= |(hit_oh & is_a);
            r_s_is_b     <= |(hit_oh & is_b);
            r_pair_ok    <= |is_a && |is_b;
            r_empty_wo_s <= ~|(r_valid & ~hit_oh);
            r_free_oh    <= free_oh;
            r_can_ins    <= !hit_found && free_found;
            r_aid        <= l_aid;
            r_ax         <= l_ax;
            r_ay         <= l_ay;
            r_bx         <= l_bx;
            r_by         <= l_by;
            r_ex         <= l_ex;
            r_ey         <= l_ey;
        end
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (i_cmd.tbl_op == TBL_INSERT && r_can_ins && r_free_oh[i]) begin
                r_id[i] <= r_pid;
                r_x[i]  <= r_px;
                r_y[i]  <= r_py;
            end else if (i_cmd.tbl_op == TBL_WRITE && r_s_oh[i]) begin
                r_x[i] <= r_px;
                r_y[i] <= r_py;
            end
        end
        r_prod <= mul_op * mul_op;
        unique case (i_cmd.acc_op)
            ACC_LOAD0: r_acc0 <= ACC_W'(r_prod);
            ACC_ADD0:  r_acc0 <= r_acc0 + ACC_W'(r_prod);
            ACC_LOAD1: r_acc1 <= ACC_W'(r_prod);
            ACC_ADD1:  r_acc1 <= r_acc1 + ACC_W'(r_prod);
            default: ;
        endcase
        if (i_cmd.div_init) begin
            r_num <= {r_acc0, FRAC_BITS'(0)};
            r_rem <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.div_step) begin
            r_num <= r_num << 1;
            r_rem <= div_ge ? ACC_W'(rem_sh - {1'b0, r_acc1}) : rem_sh[ACC_W-1:0];
            r_q   <= {r_q[Q_BITS-2:0], div_ge};
            r_ovf <= r_ovf | r_q[Q_BITS-1];
        end
        if (i_cmd.sqrt_init) begin
            r_v   <= r_q;
            r_res <= '0;
            r_bit <= Q_BITS'(1) << (Q_BITS - 2);
        end else if (i_cmd.sqrt_step) begin
            r_v   <= sq_ge ? r_v - sq_t : r_v;
            r_res <= sq_ge ? (r_res >> 1) + r_bit : r_res >> 1;
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.emit_en) begin
            r_out_kind  <= i_cmd.emit_kind;
            r_out_pkind <= (i_cmd.emit_kind == G_PRESS_START) ? r_pkind : 2'd0;
            r_out_id    <= n_out_id;
            r_out_x     <= n_out_x;
            r_out_y     <= n_out_y;
            r_out_zoom  <= (i_cmd.emit_kind != G_ZOOM) ? '0 :
                           r_ovf ? '1 : r_res[ZOOM_BITS-1:0];
            r_out_last  <= i_cmd.emit_last;
        end
    end

    assign o_status = '{
        op:         r_op,
        mode:       r_mode,
        found:      r_found,
        pair_ok:    r_pair_ok,
        empty_wo_s: r_empty_wo_s,
        d2_gt:      r_acc0 > r_acc1,
        spans_nz:   (r_acc0 != '0) && (r_acc1 != '0),
        out_free:   out_free
    };

    assign o_valid            = r_out_valid;
    assign o_gesture_kind     = r_out_kind;
    assign o_out_pointer_kind = r_out_pkind;
    assign o_out_pointer_id   = r_out_id;
    assign o_out_x            = r_out_x;
    assign o_out_y            = r_out_y;
    assign o_zoom_ratio       = r_out_zoom;
    assign o_last_of_run      = r_out_last;

    `TPDP_ASSERT(a_idle_empty, i_clk, i_rst_n, r_mode == MODE_IDLE, r_valid == '0, "idle mode with tracked pointers")
    `TPDP_ASSERT(a_single_ptr, i_clk, i_rst_n, r_mode == MODE_PRESS || r_mode == MODE_DRAG, $countones(r_valid) == 1, "press or drag without exactly one pointer")

endmodule

@@ rtl/tpdp_ctrl.sv @@
// gesture recognizer sequencer
`include "assert_macros.svh"

module tpdp_ctrl
    import tpdp_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam int DIV_STEPS = f_div_steps(COORD_BITS);
    localparam int CNT_W     = $clog2(DIV_STEPS);

    t_state           r_state, n_state;
    t_act             r_act, n_act;
    logic [1:0]       r_idx, n_idx;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    t_gesture         e_kind;
    t_id_src          e_id;
    t_xy_src          e_xy;
    logic [1:0]       e_cnt;
    logic             is_press;

    assign is_press = (r_act == ACT_MOVE_PRESS);

    // result list per action
    always_comb begin
        e_kind = G_PRESS_START;
        e_id   = ID_ZERO;
        e_xy   = XY_ZERO;
        e_cnt  = 2'd1;
        unique case (r_act)
            ACT_DOWN_IDLE: begin
                e_kind = G_PRESS_START;
                e_id   = ID_IN;
                e_xy   = XY_IN;
            end
            ACT_DOWN_PRESS: begin
                e_kind = G_PRESS_ABORT;
                e_id   = ID_FIRST;
            end
            ACT_DOWN_DRAG: begin
                e_kind = G_DRAG_END;
                e_xy   = XY_FIRST;
            end
            ACT_UP_DRAG: begin
                e_kind = G_DRAG_END;
                e_xy   = XY_IN;
            end
            ACT_UP_PRESS: begin
                e_kind = G_PRESS_END;
                e_id   = ID_IN;
                e_xy   = XY_IN;
            end
            ACT_MOVE_DRAG: begin
                e_kind = G_DRAG_MOVE;
                e_xy   = XY_IN;
            end
            ACT_MOVE_PRESS: begin
                e_cnt = 2'd3;
                unique case (r_idx)
                    2'd0: begin
                        e_kind = G_PRESS_ABORT;
                        e_id   = ID_IN;
                    end
                    2'd1: begin
                        e_kind = G_DRAG_START;
                        e_xy   = XY_ENTRY;
                    end
                    default: begin
                        e_kind = G_DRAG_MOVE;
                        e_xy   = XY_IN;
                    end
                endcase
            end
            ACT_MOVE_XFORM: e_kind = G_ZOOM;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_READY;
            r_act   <= ACT_DOWN_IDLE;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_act   <= n_act;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_act   = r_act;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_READY: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_state       = ST_LOOK;
                end
            end
            ST_LOOK: begin
                o_cmd.look_en = 1'b1;
                n_state       = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                n_state = ST_READY;
                n_idx   = '0;
                n_cnt   = '0;
                unique case (i_status.op)
                    OP_DOWN: begin
                        unique case (i_status.mode)
                            MODE_IDLE: begin
                                n_act   = ACT_DOWN_IDLE;
                                n_state = ST_EMIT;
                            end
                            MODE_PRESS: begin
                                n_act   = ACT_DOWN_PRESS;
                                n_state = ST_EMIT;
                            end
                            MODE_DRAG: begin
                                n_act   = ACT_DOWN_DRAG;
                                n_state = ST_EMIT;
                            end
                            MODE_XFORM: begin
                                n_act   = ACT_DOWN_XFORM;
                                n_state = ST_UPDATE;
                            end
                            default: ;
                        endcase
                    end
                    OP_UP: begin
                        unique case (i_status.mode)
                            MODE_NONE: begin
                                n_act   = ACT_UP_NONE;
                                n_state = ST_UPDATE;
                            end
                            MODE_XFORM: begin
                                n_act   = ACT_UP_XFORM;
                                n_state = ST_UPDATE;
                            end
                            MODE_DRAG: begin
                                n_act   = ACT_UP_DRAG;
                                n_state = ST_EMIT;
                            end
                            MODE_PRESS: begin
                                n_act   = ACT_UP_PRESS;
                                n_state = ST_EMIT;
                            end
                            default: ;
                        endcase
                    end
                    OP_MOVE: begin
                        if (i_status.found) begin
                            unique case (i_status.mode)
                                MODE_XFORM: begin
                                    n_act   = ACT_MOVE_XFORM;
                                    n_state = ST_SQ0;
                                end
                                MODE_DRAG: begin
                                    n_act   = ACT_MOVE_DRAG;
                                    n_state = ST_EMIT;
                                end
                                MODE_PRESS: begin
                                    n_act   = ACT_MOVE_PRESS;
                                    n_state = ST_SQ0;
                                end
                                default: ;
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
            ST_SQ0: begin
                o_cmd.sq_sel = is_press ? SQ_DXP : SQ_DXO;
                n_state      = ST_SQ1;
            end
            ST_SQ1: begin
                o_cmd.sq_sel = is_press ? SQ_DYP : SQ_DYO;
                o_cmd.acc_op = ACC_LOAD0;
                n_state      = ST_SQ2;
            end
            ST_SQ2: begin
                o_cmd.sq_sel = is_press ? SQ_TOL : SQ_DXN;
                o_cmd.acc_op = ACC_ADD0;
                n_state      = ST_SQ3;
            end
            ST_SQ3: begin
                o_cmd.sq_sel = SQ_DYN;
                o_cmd.acc_op = ACC_LOAD1;
                n_state      = ST_SQ4;
            end
            ST_SQ4: begin
                o_cmd.acc_op = is_press ? ACC_HOLD : ACC_ADD1;
                n_state      = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (is_press) begin
                    n_state = i_status.d2_gt ? ST_EMIT : ST_READY;
                end else if (i_status.pair_ok && i_status.spans_nz) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = ST_DIV;
                end else begin
                    n_state = ST_UPDATE;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_SQRT_INIT;
                end
            end
            ST_SQRT_INIT: begin
                o_cmd.sqrt_init = 1'b1;
                n_state         = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_en   = 1'b1;
                    o_cmd.emit_kind = e_kind;
                    o_cmd.id_src    = e_id;
                    o_cmd.xy_src    = e_xy;
                    o_cmd.emit_last = (r_idx == e_cnt - 2'd1);
                    if (r_idx == e_cnt - 2'd1) begin
                        n_state = ST_UPDATE;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
            end
            ST_UPDATE: begin
                n_state = ST_READY;
                unique case (r_act)
                    ACT_DOWN_IDLE: begin
                        o_cmd.tbl_op   = TBL_INSERT;
                        o_cmd.mode_we  = 1'b1;
                        o_cmd.mode_val = MODE_PRESS;
                    end
                    ACT_DOWN_PRESS, ACT_DOWN_DRAG: begin
                        o_cmd.tbl_op   = TBL_INSERT;
                        o_cmd.mode_we  = 1'b1;
                        o_cmd.mode_val = MODE_XFORM;
                    end
                    ACT_DOWN_XFORM: begin
                        o_cmd.tbl_op   = TBL_INSERT;
                        o_cmd.mode_we  = 1'b1;
                        o_cmd.mode_val = MODE_NONE;
                    end
                    ACT_UP_NONE: begin
                        o_cmd.tbl_op   = TBL_REMOVE;
                        o_cmd.mode_we  = 1'b1;
                        o_cmd.mode_val = i_status.empty_wo_s ? MODE_IDLE : MODE_NONE;
                    end
                    ACT_UP_XFORM: begin
                        o_cmd.tbl_op   = TBL_REMOVE;
                        o_cmd.mode_we  = 1'b1;
                        o_cmd.mode_val = MODE_NONE;
                    end
                    ACT_UP_DRAG, ACT_UP_PRESS: begin
                        o_cmd.tbl_op   = TBL_CLEAR;
                        o_cmd.mode_we  = 1'b1;
                        o_cmd.mode_val = MODE_IDLE;
                    end
                    ACT_MOVE_PRESS: begin
                        o_cmd.tbl_op   = TBL_WRITE;
                        o_cmd.mode_we  = 1'b1;
                        o_cmd.mode_val = MODE_DRAG;
                    end
                    default: o_cmd.tbl_op = TBL_WRITE;
                endcase
            end
            default: n_state = ST_READY;
        endcase
    end

    `TPDP_ASSERT(a_emit_free, i_clk, i_rst_n, o_cmd.emit_en, i_status.out_free, "result loaded while output register busy")
    `TPDP_ASSERT_NEXT(a_accept_look, i_clk, i_rst_n, o_cmd.in_load, r_state == ST_LOOK, "accepted item not looked up")

endmodule

@@ rtl/touch_press_drag_pinch_recognizer.sv @@
// sequencing: an item is accepted, looked up and dispatched; a zoom move on a pointer pair
// with nonzero spans runs 5 squaring steps, one long-division step per cycle over
// 2*max(COORD_BITS+1,16)+33 bits and 32 square-root steps; a stalled output holds it back
// throughput: one item at a time, the next is taken once the previous one's results are in
// the output register or beyond
// reset: synchronous active low, gesture mode idle, pointer table empty, tolerance 16
module touch_press_drag_pinch_recognizer
    import tpdp_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int ID_BITS    = DEF_ID_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [TOL_BITS-1:0]          i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_operation,
    input  logic [ID_BITS-1:0]           i_pointer_id,
    input  logic [1:0]                   i_pointer_kind,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [2:0]                   o_gesture_kind,
    output logic [1:0]                   o_out_pointer_kind,
    output logic [ID_BITS-1:0]           o_out_pointer_id,
    output logic signed [COORD_BITS-1:0] o_out_x,
    output logic signed [COORD_BITS-1:0] o_out_y,
    output logic [ZOOM_BITS-1:0]         o_zoom_ratio,
    output logic                         o_last_of_run
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       ready;

    assign o_stall = !ready;

    tpdp_ctrl #(
        .COORD_BITS(COORD_BITS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    tpdp_datapath #(
        .COORD_BITS(COORD_BITS),
        .ID_BITS   (ID_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_operation        (i_operation),
        .i_pointer_id       (i_pointer_id),
        .i_pointer_kind     (i_pointer_kind),
        .i_pos_x            (i_pos_x),
        .i_pos_y            (i_pos_y),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_gesture_kind     (o_gesture_kind),
        .o_out_pointer_kind (o_out_pointer_kind),
        .o_out_pointer_id   (o_out_pointer_id),
        .o_out_x            (o_out_x),
        .o_out_y            (o_out_y),
        .o_zoom_ratio       (o_zoom_ratio),
        .o_last_of_run      (o_last_of_run)
    );

endmodule
